/* rtl/wpsr_pkg.sv */
// ----------------------------------------------------------------------------
// wpsr_pkg: shared types and constants of the wrapped position stepper rate
// Command and status bundles, request and timer codes, field widths.
// ----------------------------------------------------------------------------
package wpsr_pkg;

    localparam int ENC_W        = 10;
    localparam int ENC_COUNTS   = 1 << ENC_W;
    localparam int DIFF_W       = ENC_W + 2;
    localparam int RATE_W       = 16;
    localparam int GAIN_W       = 8;
    localparam int OFF_W        = 16;
    localparam int SPD_W        = 16;
    localparam int SPD_FRAC     = 15;
    localparam int ERR_W        = 11;
    localparam int PROD_W       = 2 * RATE_W;
    localparam int HP_W         = 19;
    localparam int CNT_W        = $clog2(HP_W);
    localparam int US_PER_SEC   = 1000000;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 48;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [HP_W-1:0]   HALF_US       = HP_W'(US_PER_SEC / 2);
    localparam logic [RATE_W-1:0] MAX_RATE_RST  = RATE_W'(4000);
    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(10);
    localparam logic [DIFF_W-1:0] HALF_COUNTS   = DIFF_W'(ENC_COUNTS / 2);
    localparam logic [DIFF_W-1:0] FULL_COUNTS   = DIFF_W'(ENC_COUNTS);

    typedef enum logic [1:0] {
        REQ_POS   = 2'd0,
        REQ_SPEED = 2'd1,
        REQ_INCR  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ACT_STOP   = 2'd0,
        ACT_START  = 2'd1,
        ACT_UPDATE = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RATE = 1'd0,
        CFG_GAIN     = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL,
        ST_RATE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic err;
        logic mul;
        logic rate;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_drop;
        logic stop;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/wrapped_position_stepper_rate.sv */
// Sequence: an accepted word passes the error, multiply, rate, divide and
//           output load states; a stop result skips the bit-serial divider.
// Input ready is low while a word is in work; a waiting result does not block
// acceptance, but holds the next word in the done state until the output is free.
// Reset: synchronous active low; motor marked stopped, direction low,
//        max_step_rate 4000, position_gain 10. Words of request type 3 are dropped.
// ----------------------------------------------------------------------------
// wrapped_position_stepper_rate: stepper rate controller for a wrapped encoder
// Turns position, incremental and speed commands into timer actions, step rate
// and half period.
// ----------------------------------------------------------------------------
module wrapped_position_stepper_rate
    import wpsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // target_position, position_offset, speed_value, encoder_sample, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // direction_level, step_rate, half_period_us, position_error, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // timer_action
    output logic [1:0]            o_m_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    assign o_cfg_ready = 1'b1;

    wpsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wpsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

/* rtl/wpsr_ctrl.sv */
// ----------------------------------------------------------------------------
// wpsr_ctrl: command sequencer
// Steps each word that is not dropped through error, multiply, rate, divide and output load.
// ----------------------------------------------------------------------------
module wpsr_ctrl
    import wpsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    output logic      o_s_tready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_s_tvalid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_stat.in_drop) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_RATE;
            ST_RATE: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.stop || i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = accept;
            end
            ST_ERR:  o_cmd.err  = 1'b1;
            ST_MUL:  o_cmd.mul  = 1'b1;
            ST_RATE: o_cmd.rate = 1'b1;
            ST_DIV:  o_cmd.div_step = !i_stat.stop;
            ST_DONE: o_cmd.load_out = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/wpsr_dp.sv */
// ----------------------------------------------------------------------------
// wpsr_dp: datapath
// Wrap error, rate multiply and clamp, bit-serial half period divide,
// motor state and output register.
// ----------------------------------------------------------------------------
module wpsr_dp
    import wpsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_stat              o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [1:0]            i_s_tuser,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]            o_m_tuser
);

    logic [RATE_W-1:0]       r_max_rate;
    logic [GAIN_W-1:0]       r_gain;

    t_req                    r_req;
    logic [ENC_W-1:0]        r_tgt;
    logic [OFF_W-1:0]        r_off;
    logic [SPD_W-1:0]        r_spd;
    logic [ENC_W-1:0]        r_smp;

    logic [RATE_W-1:0]       r_mag;
    logic [ERR_W-1:0]        r_err;
    logic                    r_dir;
    logic [PROD_W-1:0]       r_prod;
    logic [RATE_W-1:0]       r_rate;
    logic                    r_stop;
    logic [RATE_W-1:0]       r_rem;
    logic [HP_W-1:0]         r_quot;
    logic [CNT_W-1:0]        r_cnt;

    logic                    r_motor_stopped;
    logic                    r_dir_state;

    logic                    r_out_valid;
    t_action                 r_out_act;
    logic                    r_out_dir;
    logic [RATE_W-1:0]       r_out_rate;
    logic [HP_W-1:0]         r_out_hp;
    logic [ERR_W-1:0]        r_out_err;

    logic [ENC_W-1:0]        tgt_eff;
    logic [DIFF_W-1:0]       diff;
    logic [DIFF_W-1:0]       dmag;
    logic [DIFF_W-1:0]       wmag;
    logic [DIFF_W-1:0]       werr;
    logic [SPD_W-1:0]        spd_abs;
    logic [RATE_W-1:0]       mul_b;
    logic [RATE_W-1:0]       n_rate;
    logic                    n_stop;
    logic [RATE_W:0]         rem_sh;
    logic [RATE_W:0]         rem_sub;
    logic                    rem_ge;
    logic                    is_speed;

    assign is_speed = (r_req == REQ_SPEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= MAX_RATE_RST;
            r_gain     <= GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_RATE: r_max_rate <= i_cfg_data;
                CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                default:      r_gain     <= r_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_s_tuser);
            r_tgt <= i_s_tdata[ENC_W-1:0];
            r_off <= i_s_tdata[ENC_W +: OFF_W];
            r_spd <= i_s_tdata[ENC_W+OFF_W +: SPD_W];
            r_smp <= i_s_tdata[ENC_W+OFF_W+SPD_W +: ENC_W];
        end
    end

    always_comb begin
        tgt_eff = (r_req == REQ_INCR) ? (r_smp + r_off[ENC_W-1:0]) : r_tgt;
        diff    = {2'b00, tgt_eff} - {2'b00, r_smp};
        dmag    = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
        wmag    = dmag;
        werr    = diff;
        if (dmag > HALF_COUNTS) begin
            wmag = FULL_COUNTS - dmag;
            werr = diff[DIFF_W-1] ? wmag : (DIFF_W'(0) - wmag);
        end
        spd_abs = r_spd[SPD_W-1] ? (SPD_W'(0) - r_spd) : r_spd;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            if (is_speed) begin
                r_mag <= spd_abs;
                r_err <= '0;
                r_dir <= !r_spd[SPD_W-1];
            end else begin
                r_mag <= RATE_W'(wmag);
                r_err <= werr[ERR_W-1:0];
                r_dir <= werr[DIFF_W-1] || (werr == '0);
            end
        end
    end

    assign mul_b = is_speed ? r_max_rate : RATE_W'(r_gain);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_mag * mul_b;
        end
    end

    always_comb begin
        if (is_speed) begin
            n_stop = (r_mag == '0);
            n_rate = r_prod[SPD_FRAC +: RATE_W];
            if (n_rate == '0) begin
                n_rate = RATE_W'(1);
            end
        end else begin
            n_rate = (r_prod > PROD_W'(r_max_rate)) ? r_max_rate : r_prod[RATE_W-1:0];
            n_stop = (r_mag <= RATE_W'(1)) || (n_rate == '0);
        end
    end

    assign rem_sh  = {r_rem, HALF_US[r_cnt]};
    assign rem_ge  = (rem_sh >= {1'b0, r_rate});
    assign rem_sub = rem_sh - {1'b0, r_rate};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rate) begin
            r_rate <= n_rate;
            r_stop <= n_stop;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= CNT_W'(HP_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            r_quot <= {r_quot[HP_W-2:0], rem_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_stopped <= 1'b1;
            r_dir_state     <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_motor_stopped <= r_stop;
            if (!r_stop) begin
                r_dir_state <= r_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_err <= r_err;
            if (r_stop) begin
                r_out_act  <= ACT_STOP;
                r_out_dir  <= r_dir_state;
                r_out_rate <= '0;
                r_out_hp   <= '0;
            end else begin
                r_out_act  <= r_motor_stopped ? ACT_START : ACT_UPDATE;
                r_out_dir  <= r_dir;
                r_out_rate <= r_rate;
                r_out_hp   <= r_quot;
            end
        end
    end

    assign o_stat.in_drop  = (t_req'(i_s_tuser) == REQ_NONE);
    assign o_stat.stop     = r_stop;
    assign o_stat.div_last = (r_cnt == '0);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_act;
    assign o_m_tdata  = {1'b0, r_out_err, r_out_hp, r_out_rate, r_out_dir};

endmodule

/* rtl/wpsr_chk.sv */
// ----------------------------------------------------------------------------
// wpsr_chk: port checker
// Watches the top level ports for result consistency and word handling.
// ----------------------------------------------------------------------------
module wpsr_chk
    import wpsr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [1:0]            i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [1:0]            o_m_tuser
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser != REQ_NONE)) |=> !o_s_tready)
        else $error("input ready high right after accepting a command word");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ACT_STOP)) |->
        ((o_m_tdata[RATE_W:1] == '0) && (o_m_tdata[RATE_W+1 +: HP_W] == '0)))
        else $error("stop result with nonzero rate or half period");

    a_move_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ACT_STOP)) |->
        ((o_m_tdata[RATE_W:1] != '0) && (o_m_tdata[RATE_W+1 +: HP_W] != '0)
         && (o_m_tuser != 2'd3)))
        else $error("moving result with zero rate, zero half period or bad action");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result word changed while stalled");

endmodule

bind wrapped_position_stepper_rate wpsr_chk u_wpsr_chk (.*);
